FILE: hdl/bced_pkg.sv
// shared types and constants for the button click event detector
// no dependencies; used by bced_step and button_click_event_detector_core
package bced_pkg;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PRESSED = 2'd1,
        PH_WAIT    = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_LONG   = 2'd1,
        EV_CLICK  = 2'd2,
        EV_DOUBLE = 2'd3
    } event_t;

    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 8;

    localparam logic [CfgIndexWidth-1:0] CFG_DEBOUNCE_SAMPLES = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_LONG_PRESS_TICKS = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_CLICK_GAP_TICKS  = 2'd2;

    localparam logic [3:0] DEBOUNCE_SAMPLES_RST = 4'd3;
    localparam logic [7:0] LONG_PRESS_TICKS_RST = 8'd50;
    localparam logic [7:0] CLICK_GAP_TICKS_RST  = 8'd15;

    localparam logic [7:0] TICK_MAX     = 8'd255;
    localparam logic [3:0] MISMATCH_MAX = 4'd15;
    localparam logic [1:0] PRESS_MAX    = 2'd3;

    typedef struct packed {
        logic [3:0] debounce_samples;
        logic [7:0] long_press_ticks;
        logic [7:0] click_gap_ticks;
    } cfg_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] tick_count;
        logic [1:0] press_count;
        logic       debounced_level;
        logic [3:0] mismatch_count;
    } state_t;

endpackage

FILE: hdl/bced_step.sv
// one-tick update of debouncer and click phase machine, pure combinational
// depends on bced_pkg
module bced_step (
    input  bced_pkg::cfg_t   cfg,
    input  bced_pkg::state_t state_cur,
    input  logic             pin_level,
    output bced_pkg::state_t state_nxt,
    output bced_pkg::event_t event_res
);

    always_comb begin
        logic [7:0] tick;
        logic [3:0] mism;
        logic       lvl;
        bced_pkg::phase_t ph;
        logic [1:0] presses;

        tick    = state_cur.tick_count;
        mism    = state_cur.mismatch_count;
        lvl     = state_cur.debounced_level;
        ph      = state_cur.phase;
        presses = state_cur.press_count;
        event_res = bced_pkg::EV_NONE;

        // tick counter runs outside idle, saturating
        if (state_cur.phase != bced_pkg::PH_IDLE && tick != bced_pkg::TICK_MAX) begin
            tick = tick + 8'd1;
        end

        // debouncer
        if (lvl != pin_level) begin
            if (mism != bced_pkg::MISMATCH_MAX) begin
                mism = mism + 4'd1;
            end
            if (mism >= cfg.debounce_samples) begin
                lvl  = pin_level;
                mism = 4'd0;
            end
        end else begin
            mism = 4'd0;
        end

        case (state_cur.phase)
            bced_pkg::PH_PRESSED: begin
                if (lvl) begin
                    tick = 8'd0;
                    ph   = bced_pkg::PH_WAIT;
                end else if (tick >= cfg.long_press_ticks) begin
                    // long press repeats and cancels the pending click
                    event_res = bced_pkg::EV_LONG;
                    tick      = 8'd0;
                    presses   = 2'd0;
                end
            end
            bced_pkg::PH_WAIT: begin
                if (tick > cfg.click_gap_ticks) begin
                    if (presses == 2'd1) begin
                        event_res = bced_pkg::EV_CLICK;
                    end else if (presses == 2'd2) begin
                        event_res = bced_pkg::EV_DOUBLE;
                    end
                    ph = bced_pkg::PH_IDLE;
                end else if (!lvl) begin
                    if (presses != bced_pkg::PRESS_MAX) begin
                        presses = presses + 2'd1;
                    end
                    ph   = bced_pkg::PH_PRESSED;
                    tick = 8'd0;
                end
            end
            default: begin
                // idle, and the unused code behaves as idle
                ph = bced_pkg::PH_IDLE;
                if (!lvl) begin
                    ph      = bced_pkg::PH_PRESSED;
                    tick    = 8'd0;
                    presses = 2'd1;
                end
            end
        endcase

        state_nxt.phase           = ph;
        state_nxt.tick_count      = tick;
        state_nxt.press_count     = presses;
        state_nxt.debounced_level = lvl;
        state_nxt.mismatch_count  = mism;
    end

endmodule

FILE: hdl/button_click_event_detector_core.sv
// top level of the button click event detector: config registers, state, output stage
// depends on bced_pkg and bced_step
//
// usage
//   s_ channel: one raw pin sample per beat, s_tdata[0] = pin_level (0 = pressed)
//   m_ channel: one result beat per input beat, in order
//     m_tdata[1:0] = event_res (0 none, 1 long press, 2 click, 3 double click)
//     m_tdata[2]   = stable_level, the debounced level after this sample
//   cfg port: cfg_wr_en with cfg_index selects debounce_samples (0),
//     long_press_ticks (1) or click_gap_ticks (2); other indexes are dropped
// the result of a sample is registered and is on m_ in the cycle after its beat is accepted
// throughput: one sample per cycle unless the output stalls, the whole tick update is one combinational
//   pass from the state registers into the result register
// stall: s_tready drops only while a result is held and m_tready is low;
//   the held result and the state stay put until it is taken
// reset: aresetn low clears the phase machine and debouncer (level released),
//   loads the default config (3, 50, 15) and empties the output stage
module button_click_event_detector_core (
    input  logic       aclk,
    input  logic       aresetn,
    // input channel
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [0] pin_level, [7:1] zero
    // result channel
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [1:0] event_res, [2] stable_level, [7:3] zero
    // config write port
    input  logic                               cfg_wr_en,
    input  logic [bced_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [bced_pkg::CfgDataWidth-1:0]  cfg_wdata
);

    bced_pkg::cfg_t   cfg_reg;
    bced_pkg::state_t state_reg;
    bced_pkg::state_t state_next;
    bced_pkg::event_t event_next;

    logic       m_valid_reg;
    logic [1:0] m_event_reg;
    logic       m_level_reg;
    logic       s_beat;

    // accept whenever the output stage is empty or being drained this cycle
    assign s_tready = !m_valid_reg || m_tready;
    assign s_beat   = s_tvalid && s_tready;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_samples <= bced_pkg::DEBOUNCE_SAMPLES_RST;
            cfg_reg.long_press_ticks <= bced_pkg::LONG_PRESS_TICKS_RST;
            cfg_reg.click_gap_ticks  <= bced_pkg::CLICK_GAP_TICKS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bced_pkg::CFG_DEBOUNCE_SAMPLES: cfg_reg.debounce_samples <= cfg_wdata[3:0];
                bced_pkg::CFG_LONG_PRESS_TICKS: cfg_reg.long_press_ticks <= cfg_wdata;
                bced_pkg::CFG_CLICK_GAP_TICKS:  cfg_reg.click_gap_ticks  <= cfg_wdata;
                default: begin
                    // index beyond the register list, ignored
                end
            endcase
        end
    end

    // tick update
    bced_step u_step (
        .cfg       (cfg_reg),
        .state_cur (state_reg),
        .pin_level (s_tdata[0]),
        .state_nxt (state_next),
        .event_res (event_next)
    );

    // detector state advances once per accepted sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase           <= bced_pkg::PH_IDLE;
            state_reg.tick_count      <= 8'd0;
            state_reg.press_count     <= 2'd0;
            state_reg.debounced_level <= 1'b1;
            state_reg.mismatch_count  <= 4'd0;
        end else if (s_beat) begin
            state_reg <= state_next;
        end
    end

    // output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_beat) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            m_event_reg <= event_next;
            m_level_reg <= state_next.debounced_level;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_level_reg, m_event_reg};

endmodule

FILE: tb/button_click_event_detector_core_test.sv
// self-checking testbench for button_click_event_detector_core: drives pin samples,
// predicts each result beat in step with the accepted input beats and compares them
// depends on bced_pkg and the block's rtl
module button_click_event_detector_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bced_pkg::*;

    // cycles with no beat on either side before the run is declared hung
    localparam int WatchdogLimit = 2000;
    // random pin samples per config setting, cut back to this after generation except in the full-gesture setting
    localparam int SegmentSamples = 55;
    // setting with the gap at its maximum, keeps its whole gesture so the tick counter saturates
    localparam int FullGestureSegment = 5;
    // register index that maps to nothing, writes to it are dropped
    localparam logic [CfgIndexWidth-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef struct packed {
        event_t ev;
        logic   level;
    } click_result_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [7:0]               s_tdata   = '0;  // [0] pin_level, [7:1] zero
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [7:0]               m_tdata;         // [1:0] event_res, [2] stable_level
    logic                     cfg_wr_en = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [CfgDataWidth-1:0]  cfg_wdata = '0;

    // pin samples waiting for the driver, and results owed by the block
    logic          pin_queue[$];
    click_result_t expected_results[$];

    // predictor copy of the detector state and its registers
    state_t det;
    cfg_t   det_cfg;

    int idle_mode;        // 0: sender light, receiver heavy; 1: swapped; 2: no idling
    int error_count;
    int samples_queued;
    int quiet_cycles;

    button_click_event_detector_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // one tick of the detector: tick counter, then debouncer, then the phase machine
    function automatic click_result_t tick_detector(input logic pin);
        click_result_t r;
        r.ev = EV_NONE;
        // tick counter only runs outside idle and sticks at its maximum
        if (det.phase != PH_IDLE && det.tick_count != TICK_MAX)
            det.tick_count = det.tick_count + 8'd1;
        // debouncer: adopt the raw level after enough differing samples in a row
        if (det.debounced_level != pin) begin
            if (det.mismatch_count != MISMATCH_MAX)
                det.mismatch_count = det.mismatch_count + 4'd1;
            if (det.mismatch_count >= det_cfg.debounce_samples) begin
                det.debounced_level = pin;
                det.mismatch_count  = 4'd0;
            end
        end else begin
            det.mismatch_count = 4'd0;
        end
        case (det.phase)
            PH_PRESSED: begin
                if (det.debounced_level) begin
                    det.tick_count = 8'd0;
                    det.phase      = PH_WAIT;
                end else if (det.tick_count >= det_cfg.long_press_ticks) begin
                    // long press repeats and wipes any pending click
                    r.ev            = EV_LONG;
                    det.tick_count  = 8'd0;
                    det.press_count = 2'd0;
                end
            end
            PH_WAIT: begin
                if (det.tick_count > det_cfg.click_gap_ticks) begin
                    // sequence over: three or more presses report nothing
                    if (det.press_count == 2'd1)
                        r.ev = EV_CLICK;
                    else if (det.press_count == 2'd2)
                        r.ev = EV_DOUBLE;
                    det.phase = PH_IDLE;
                end else if (!det.debounced_level) begin
                    if (det.press_count != PRESS_MAX)
                        det.press_count = det.press_count + 2'd1;
                    det.phase      = PH_PRESSED;
                    det.tick_count = 8'd0;
                end
            end
            default: begin
                // idle, and the unused phase code behaves the same
                det.phase = PH_IDLE;
                if (!det.debounced_level) begin
                    det.phase       = PH_PRESSED;
                    det.tick_count  = 8'd0;
                    det.press_count = 2'd1;
                end
            end
        endcase
        r.level = det.debounced_level;
        return r;
    endfunction

    // random stall decision for this cycle, sender or receiver side
    function automatic bit idles(input bit sender);
        int pct;
        case (idle_mode)
            0:       pct = sender ? 37 : 85;
            1:       pct = sender ? 85 : 37;
            default: pct = 0;
        endcase
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        $display("%0t ns: %s", $time, msg);
    endtask

    task automatic add_run(input logic lvl, input int n);
        repeat (n) begin
            pin_queue.push_back(lvl);
            samples_queued++;
        end
    endtask

    // contact bounce or plain garbage on the pin
    task automatic add_noise(input int n);
        repeat (n) begin
            pin_queue.push_back(1'($urandom));
            samples_queued++;
        end
    endtask

    // pin samples written as a string of '0' and '1', oldest first
    task automatic add_pattern(input string pat);
        for (int i = 0; i < pat.len(); i++)
            add_run(pat.getc(i) == "0" ? 1'b0 : 1'b1, 1);
    endtask

    // register writes are driven onto the config port with nonblocking assignments, predictor follows at once
    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                             input logic [CfgDataWidth-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_DEBOUNCE_SAMPLES: det_cfg.debounce_samples = value[3:0];
            CFG_LONG_PRESS_TICKS: det_cfg.long_press_ticks = value;
            CFG_CLICK_GAP_TICKS:  det_cfg.click_gap_ticks  = value;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // hold off until every queued sample went in and every result came out
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pin_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
    endtask

    // driver: offers the next pin sample once the previous beat is gone
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pin_queue.size() != 0 && !idles(1'b1)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, pin_queue.pop_front()};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: predicts on every input beat and checks every result beat
    always @(posedge aclk) begin
        click_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_results.push_back(tick_detector(s_tdata[0]));
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_error($sformatf("result beat 0x%02h with nothing expected", m_tdata));
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[1:0] !== want.ev)
                        report_error($sformatf("event_res expected %s, got %b",
                                               want.ev.name(), m_tdata[1:0]));
                    if (m_tdata[2] !== want.level)
                        report_error($sformatf("stable_level expected %b, got %b",
                                               want.level, m_tdata[2]));
                end
            end
        end
        m_tready <= !idles(1'b0);
    end

    // watchdog: ends a hung run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("button_click_event_detector_core_test failed");
            $finish;
        end
    end

    initial begin
        logic [23:0] setting;    // {debounce, long press, gap} bytes
        int db;
        int lp;
        int gap;
        int presses;
        int hold;
        int release_len;
        int start;

        // predictor starts from the reset state and default registers
        det.phase                = PH_IDLE;
        det.tick_count           = 8'd0;
        det.press_count          = 2'd0;
        det.debounced_level      = 1'b1;
        det.mismatch_count       = 4'd0;
        det_cfg.debounce_samples = DEBOUNCE_SAMPLES_RST;
        det_cfg.long_press_ticks = LONG_PRESS_TICKS_RST;
        det_cfg.click_gap_ticks  = CLICK_GAP_TICKS_RST;
        idle_mode = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset registers: a two-sample bounce is rejected, three lows press
        add_pattern("001000");
        wait_drained();

        // tiny timings so each gesture fits in a few samples
        write_reg(CFG_DEBOUNCE_SAMPLES, 8'd1);
        write_reg(CFG_LONG_PRESS_TICKS, 8'd3);
        write_reg(CFG_CLICK_GAP_TICKS, 8'd1);
        @(negedge aclk);
        add_pattern("111");          // release ends the pending press as a click
        add_pattern("010111");       // double click
        add_pattern("0000111");      // long press, then a release that reports nothing
        add_pattern("0101010111");   // four presses, count sticks at three, nothing reported

        // random gestures under a range of settings, extremes included
        for (int seg = 0; seg < 9; seg++) begin
            wait_drained();
            idle_mode = seg / 3;
            case (seg)
                0: setting = {8'd3, 8'd50, 8'd15};
                1: setting = {8'd1, 8'd8, 8'd3};
                2: setting = {8'd0, 8'd0, 8'd0};       // instant debounce, long press every tick
                3: setting = {8'd15, 8'd255, 8'd254};
                4: setting = {4'hA, 4'd2, 8'd12, 8'd5}; // junk above the debounce field
                5: setting = {8'd0, 8'd6, 8'd255};     // gap can never be exceeded
                6: setting = {8'd4, 8'd1, 8'd1};
                7: setting = {8'd1, 8'd20, 8'd8};
                default: setting = {8'd2, 8'd5, 8'd2};
            endcase
            write_reg(CFG_DEBOUNCE_SAMPLES, setting[23:16]);
            write_reg(CFG_LONG_PRESS_TICKS, setting[15:8]);
            write_reg(CFG_CLICK_GAP_TICKS, setting[7:0]);
            if (seg == 4)
                write_reg(CFG_UNUSED_INDEX, 8'($urandom));
            @(negedge aclk);

            db    = det_cfg.debounce_samples;
            lp    = det_cfg.long_press_ticks;
            gap   = det_cfg.click_gap_ticks;
            start = samples_queued;
            while (samples_queued - start < SegmentSamples) begin
                if ($urandom_range(0, 9) == 0) begin
                    add_noise($urandom_range(4, 20));
                end else begin
                    presses = $urandom_range(1, 4);
                    for (int p = 0; p < presses; p++) begin
                        add_noise($urandom_range(0, db));
                        // mostly click-length holds, some medium, some past the long press
                        case ($urandom_range(0, 7))
                            0, 1, 2, 3, 4: hold = $urandom_range(db + 1, db + 6);
                            5, 6:          hold = $urandom_range(1, lp + db + 1);
                            default:       hold = lp + db + 1 + $urandom_range(0, lp + 3);
                        endcase
                        add_run(1'b0, hold);
                        add_noise($urandom_range(0, db));
                        // short gaps between presses, a long one to close the gesture
                        if (p < presses - 1)
                            release_len = $urandom_range(1, db + 1 + (gap < 8 ? gap : 8));
                        else
                            release_len = db + gap + $urandom_range(2, 6);
                        add_run(1'b1, release_len);
                    end
                end
            end
            // queue holds only this setting's samples here, trim the overrun
            if (seg != FullGestureSegment) begin
                while (samples_queued - start > SegmentSamples) begin
                    void'(pin_queue.pop_back());
                    samples_queued--;
                end
            end
        end

        wait_drained();
        // results are registered after their beat, leave room for strays
        repeat (3) @(posedge aclk);
        if (error_count == 0)
            $display("button_click_event_detector_core_test passed");
        else
            $display("button_click_event_detector_core_test failed");
        $finish;
    end

endmodule
